FILE: src/kmh_pkg.sv
`timescale 1ns / 1ps

package kmh_pkg;

  localparam int RUN_W  = 4;
  localparam int KEY_W  = 64;
  localparam int LIVE_W = 5;
  localparam int ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_DROP    = 2'd2,
    ACT_CLEAR   = 2'd3
  } kmh_action_e;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [RUN_W-1:0] run_number;
    logic [KEY_W-1:0] record_key;
  } kmh_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]  min_key;
    logic [RUN_W-1:0]  min_run;
    logic              heap_empty;
    logic [LIVE_W-1:0] live_runs;
    logic              rejected;
  } kmh_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_UP_READ,
    ST_UP_EVAL,
    ST_DN_LOAD,
    ST_DN_READ,
    ST_DN_EVAL,
    ST_FINISH
  } kmh_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_REJECT,
    OP_ADD_INIT,
    OP_REP_INIT,
    OP_DROP_INIT,
    OP_DROP_LOAD,
    OP_UP_READ,
    OP_UP_EVAL,
    OP_DN_READ,
    OP_DN_EVAL,
    OP_EMIT
  } kmh_op_e;

  typedef struct packed {
    kmh_op_e op;
  } kmh_cmd_t;

  typedef struct packed {
    kmh_action_e action;
    logic        full;
    logic        empty;
    logic        last;
    logic        pos_zero;
    logic        has_left;
    logic        up_less;
    logic        dn_move;
    logic        out_free;
  } kmh_status_t;

endpackage

FILE: src/kmh_stream_if.sv
`timescale 1ns / 1ps

interface kmh_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: src/kway_merge_heap_core.sv
`timescale 1ns / 1ps

// K-way merge heap core. Holds up to MAX_RUNS live runs in a binary min-heap
// ordered by each run's head record (unsigned key, ties to the lower run
// number) and takes one action word at a time on req_i: add a run with its
// first record, replace the top record, drop the top run, or clear. Each
// action returns exactly one result word on rsp_o with the smallest record,
// its run, the empty flag, the live count and a reject flag (add to a full
// heap, replace or drop on an empty one; the heap is left as it was). One
// action is in flight at a time: a word is taken, the sequencer sifts the
// heap through a single RAM with one write and two registered read ports,
// and the next word is taken once the result sits in the output register.
// Clear, reject and drop of the last run do not sift; an add sifts up, a
// replace sifts down, and a drop moves the last entry to the top and sifts
// down a heap one entry smaller. The result waits until the output register
// is free. The heap store needs no clearing after reset; only live entries
// are ever used.
module kway_merge_heap_core
  import kmh_pkg::*;
#(
  parameter int MAX_RUNS = 16,
  parameter int KEY_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kmh_stream_if.sink   req_i,
  kmh_stream_if.source rsp_o
);

  kmh_cmd_t    cmd;
  kmh_status_t status;
  logic        req_ready;
  logic        rsp_valid;
  kmh_rsp_t    rsp;

  // Sequence the action: dispatch, sift up or down, then emit.
  kmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .status_i    (status),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  // Hold the heap, the moving entry, the top copy and the result register.
  kmh_dp #(
    .MAX_RUNS (MAX_RUNS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i.payload),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .status_o    (status)
  );

  assign req_i.ready   = req_ready;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp;

endmodule

FILE: src/kmh_ram.sv
`timescale 1ns / 1ps

module kmh_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: src/kmh_ctrl.sv
`timescale 1ns / 1ps

module kmh_ctrl
  import kmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  kmh_status_t status_i,
  output logic        req_ready_o,
  output kmh_cmd_t    cmd_o
);

  kmh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.action)
          ACT_ADD: begin
            if (status_i.full) begin
              cmd_o.op = OP_REJECT;
              state_d  = ST_FINISH;
            end else begin
              cmd_o.op = OP_ADD_INIT;
              state_d  = ST_UP_READ;
            end
          end
          ACT_REPLACE: begin
            if (status_i.empty) begin
              cmd_o.op = OP_REJECT;
              state_d  = ST_FINISH;
            end else begin
              cmd_o.op = OP_REP_INIT;
              state_d  = ST_DN_READ;
            end
          end
          ACT_DROP: begin
            if (status_i.empty) begin
              cmd_o.op = OP_REJECT;
              state_d  = ST_FINISH;
            end else begin
              cmd_o.op = OP_DROP_INIT;
              state_d  = status_i.last ? ST_FINISH : ST_DN_LOAD;
            end
          end
          default: begin
            cmd_o.op = OP_CLEAR;
            state_d  = ST_FINISH;
          end
        endcase
      end
      ST_UP_READ: begin
        cmd_o.op = OP_UP_READ;
        state_d  = status_i.pos_zero ? ST_FINISH : ST_UP_EVAL;
      end
      ST_UP_EVAL: begin
        cmd_o.op = OP_UP_EVAL;
        state_d  = status_i.up_less ? ST_UP_READ : ST_FINISH;
      end
      ST_DN_LOAD: begin
        cmd_o.op = OP_DROP_LOAD;
        state_d  = ST_DN_READ;
      end
      ST_DN_READ: begin
        cmd_o.op = OP_DN_READ;
        state_d  = status_i.has_left ? ST_DN_EVAL : ST_FINISH;
      end
      ST_DN_EVAL: begin
        cmd_o.op = OP_DN_EVAL;
        state_d  = status_i.dn_move ? ST_DN_READ : ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/kmh_dp.sv
`timescale 1ns / 1ps

module kmh_dp
  import kmh_pkg::*;
#(
  parameter int MAX_RUNS = 16,
  parameter int KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kmh_cmd_t    cmd_i,
  input  kmh_req_t    req_i,
  input  logic        rsp_ready_i,
  output logic        rsp_valid_o,
  output kmh_rsp_t    rsp_o,
  output kmh_status_t status_o
);

  localparam int AW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int IW = AW + 2;
  localparam int EW = KEY_BITS + RUN_W;

  // Entries are {key, run} so one unsigned compare orders by key, then run.
  kmh_action_e         act_q;
  logic [RUN_W-1:0]    run_q;
  logic [KEY_BITS-1:0] key_q;
  logic                rej_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [EW-1:0]       ent_q, ent_d;
  logic [EW-1:0]       top_q;
  logic                out_valid_q;
  kmh_rsp_t            out_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [EW-1:0] rdata_a, rdata_b;

  logic [AW-1:0] parent;
  logic [IW-1:0] left_w, right_w, cnt_w;
  logic          has_left, has_right;
  logic          up_less, l_lt_e, r_lt_e, r_lt_l, pick_r, dn_move;
  logic [AW-1:0] child_idx;
  logic [EW-1:0] child_ent;
  logic          out_free;

  kmh_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_RUNS),
    .AW    (AW)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign parent    = (pos_q - AW'(1)) >> 1;
  assign left_w    = IW'({pos_q, 1'b1});
  assign right_w   = left_w + IW'(1);
  assign cnt_w     = IW'(cnt_q);
  assign has_left  = left_w < cnt_w;
  assign has_right = right_w < cnt_w;

  assign up_less   = ent_q < rdata_a;
  assign l_lt_e    = has_left && (rdata_a < ent_q);
  assign r_lt_e    = has_right && (rdata_b < ent_q);
  assign r_lt_l    = has_right && (rdata_b < rdata_a);
  assign pick_r    = l_lt_e ? r_lt_l : r_lt_e;
  assign dn_move   = l_lt_e || r_lt_e;
  assign child_idx = pick_r ? right_w[AW-1:0] : left_w[AW-1:0];
  assign child_ent = pick_r ? rdata_b : rdata_a;

  assign out_free  = !out_valid_q || rsp_ready_i;

  // Read ports: port A serves the parent, the left child or the last entry.
  always_comb begin
    case (cmd_i.op)
      OP_DROP_INIT: raddr_a = AW'(cnt_q - CW'(1));
      OP_UP_READ:   raddr_a = parent;
      default:      raddr_a = left_w[AW-1:0];
    endcase
    raddr_b = right_w[AW-1:0];
  end

  // Hole-style sift: the moving entry stays in ent_q until its slot is found.
  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = ent_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    ent_d = ent_q;
    case (cmd_i.op)
      OP_CLEAR: cnt_d = '0;
      OP_ADD_INIT: begin
        ent_d = {key_q, run_q};
        pos_d = AW'(cnt_q);
        cnt_d = cnt_q + CW'(1);
      end
      OP_REP_INIT: begin
        ent_d = {key_q, top_q[RUN_W-1:0]};
        pos_d = '0;
      end
      OP_DROP_INIT: begin
        cnt_d = cnt_q - CW'(1);
        pos_d = '0;
      end
      OP_DROP_LOAD: ent_d = rdata_a;
      OP_UP_READ:   we = (pos_q == '0);
      OP_UP_EVAL: begin
        we = 1'b1;
        if (up_less) begin
          wdata = rdata_a;
          pos_d = parent;
        end
      end
      OP_DN_READ:   we = !has_left;
      OP_DN_EVAL: begin
        we = 1'b1;
        if (dn_move) begin
          wdata = child_ent;
          pos_d = child_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    ent_q <= ent_d;
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
    if (cmd_i.op == OP_LATCH) begin
      act_q <= kmh_action_e'(req_i.action);
      run_q <= req_i.run_number;
      key_q <= req_i.record_key[KEY_BITS-1:0];
      rej_q <= 1'b0;
    end else if (cmd_i.op == OP_REJECT) begin
      rej_q <= 1'b1;
    end
    if (cmd_i.op == OP_EMIT) begin
      out_q.heap_empty <= (cnt_q == '0);
      out_q.live_runs  <= LIVE_W'(cnt_q);
      out_q.rejected   <= rej_q;
      if (cnt_q == '0) begin
        out_q.min_key <= '0;
        out_q.min_run <= '0;
      end else begin
        out_q.min_key <= KEY_W'(top_q[EW-1:RUN_W]);
        out_q.min_run <= top_q[RUN_W-1:0];
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  always_comb begin
    status_o.action   = act_q;
    status_o.full     = cnt_q >= CW'(MAX_RUNS);
    status_o.empty    = cnt_q == '0;
    status_o.last     = cnt_q == CW'(1);
    status_o.pos_zero = pos_q == '0;
    status_o.has_left = has_left;
    status_o.up_less  = up_less;
    status_o.dn_move  = dn_move;
    status_o.out_free = out_free;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RUNS))
    else $error("heap count above capacity");

  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) < cnt_q))
    else $error("heap write outside live entries");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> out_free)
    else $error("result overwritten before it was taken");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |=> (out_q.heap_empty == (out_q.live_runs == '0)
                               || (CW > LIVE_W)))
    else $error("empty flag disagrees with live count");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import kmh_pkg::*;

  localparam int HEAP_DEPTH = 16;
  localparam int WORD_COUNT = 1550;
  localparam int QUIET_TAIL = 200;

  // Mirror of the merge heap: run number and head record per position, plus
  // the expected result words in arrival order.
  class heap_scoreboard;
    bit [RUN_W-1:0] run_at[HEAP_DEPTH];
    bit [KEY_W-1:0] key_at[HEAP_DEPTH];
    int unsigned    live;
    kmh_rsp_t       pending[$];
    int             errors;
    int             checked;
    int             full_rejects;
    int             empty_rejects;
    int             clears;

    function new();
      live = 0;
      errors = 0;
      checked = 0;
      full_rejects = 0;
      empty_rejects = 0;
      clears = 0;
    endfunction

    // Lower key first; equal keys go to the lower run number.
    function bit ranks_above(int unsigned a, int unsigned b);
      if (key_at[a] != key_at[b]) return key_at[a] < key_at[b];
      return run_at[a] < run_at[b];
    endfunction

    function void swap_pos(int unsigned a, int unsigned b);
      bit [RUN_W-1:0] r;
      bit [KEY_W-1:0] k;
      r = run_at[a];
      k = key_at[a];
      run_at[a] = run_at[b];
      key_at[a] = key_at[b];
      run_at[b] = r;
      key_at[b] = k;
    endfunction

    function void bubble_up(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (!ranks_above(pos, parent)) break;
        swap_pos(pos, parent);
        pos = parent;
      end
    endfunction

    function void bubble_down(int unsigned pos);
      int unsigned left, right, best;
      forever begin
        left = 2 * pos + 1;
        right = left + 1;
        best = pos;
        if (left < live && ranks_above(left, best)) best = left;
        if (right < live && ranks_above(right, best)) best = right;
        if (best == pos) break;
        swap_pos(pos, best);
        pos = best;
      end
    endfunction

    // Apply one accepted action word and queue the result it must produce.
    function void note_word(kmh_req_t w);
      kmh_rsp_t exp_rsp;
      bit       bad;
      bad = 1'b0;
      case (kmh_action_e'(w.action))
        ACT_ADD: begin
          if (live >= HEAP_DEPTH) begin
            bad = 1'b1;
            full_rejects++;
          end else begin
            run_at[live] = w.run_number;
            key_at[live] = w.record_key;
            live++;
            bubble_up(live - 1);
          end
        end
        ACT_REPLACE: begin
          if (live == 0) begin
            bad = 1'b1;
            empty_rejects++;
          end else begin
            key_at[0] = w.record_key;
            bubble_down(0);
          end
        end
        ACT_DROP: begin
          if (live == 0) begin
            bad = 1'b1;
            empty_rejects++;
          end else begin
            live--;
            if (live > 0) begin
              run_at[0] = run_at[live];
              key_at[0] = key_at[live];
              bubble_down(0);
            end
          end
        end
        default: begin
          live = 0;
          clears++;
        end
      endcase
      if (live > 0) begin
        exp_rsp.min_key = key_at[0];
        exp_rsp.min_run = run_at[0];
        exp_rsp.heap_empty = 1'b0;
      end else begin
        exp_rsp.min_key = '0;
        exp_rsp.min_run = '0;
        exp_rsp.heap_empty = 1'b1;
      end
      exp_rsp.live_runs = LIVE_W'(live);
      exp_rsp.rejected = bad;
      pending = {pending, exp_rsp};
    endfunction

    task report(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
      errors++;
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task check_word(kmh_rsp_t r);
      kmh_rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected result word", r.min_key, '0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.min_key !== e.min_key) report("min_key", r.min_key, e.min_key);
      if (r.min_run !== e.min_run) report("min_run", KEY_W'(r.min_run), KEY_W'(e.min_run));
      if (r.heap_empty !== e.heap_empty)
        report("heap_empty", KEY_W'(r.heap_empty), KEY_W'(e.heap_empty));
      if (r.live_runs !== e.live_runs)
        report("live_runs", KEY_W'(r.live_runs), KEY_W'(e.live_runs));
      if (r.rejected !== e.rejected)
        report("rejected", KEY_W'(r.rejected), KEY_W'(e.rejected));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;
  int   words_sent = 0;
  int   stall_left = 0;

  heap_scoreboard sb = new();

  kmh_stream_if #(.payload_t(kmh_req_t)) req_if ();
  kmh_stream_if #(.payload_t(kmh_rsp_t)) rsp_if ();

  kway_merge_heap_core #(
    .MAX_RUNS(HEAP_DEPTH),
    .KEY_BITS(KEY_W)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  // Hold a word on req until taken; optionally idle first.
  task automatic send_word(input kmh_action_e act, input logic [RUN_W-1:0] run,
                           input logic [KEY_W-1:0] key);
    kmh_req_t w;
    int       gap;
    w.action = act;
    w.run_number = run;
    w.record_key = key;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= w;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  // Mix of extremes, near-ties and full-width keys.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom_range(0, 5));
      4: return {1'b1, 31'($urandom), 32'($urandom)};
      5: return {32'hFFFF_FFFF, 32'($urandom_range(0, 3))};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Next record of the top run: usually at or just above the current head,
  // as a merge of sorted runs would deliver it.
  function automatic logic [KEY_W-1:0] next_record();
    logic [KEY_W-1:0] head;
    if (sb.live == 0 || $urandom_range(0, 3) == 0) return pick_key();
    head = sb.key_at[0];
    if (head > {KEY_W{1'b1}} - KEY_W'(8)) return '1;
    return head + KEY_W'($urandom_range(0, 4));
  endfunction

  function automatic logic [RUN_W-1:0] pick_run();
    return RUN_W'($urandom_range(0, HEAP_DEPTH - 1));
  endfunction

  // One merge pass: optional clear, load runs, advance the top, drain.
  task automatic merge_session();
    int n, steps;
    if ($urandom_range(0, 1)) send_word(ACT_CLEAR, pick_run(), pick_key());
    n = $urandom_range(1, HEAP_DEPTH + 1);
    for (int i = 0; i < n; i++) send_word(ACT_ADD, pick_run(), pick_key());
    steps = $urandom_range(n, 3 * n + 4);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 9) < 7) send_word(ACT_REPLACE, pick_run(), next_record());
      else send_word(ACT_DROP, pick_run(), pick_key());
    end
    while (sb.live > 0) send_word(ACT_DROP, pick_run(), pick_key());
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) send_word(ACT_DROP, pick_run(), pick_key());
      else send_word(ACT_REPLACE, pick_run(), pick_key());
    end
  endtask

  // Receiver: take result words, stalling in bursts.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_word(rsp_if.payload);
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d result words outstanding", sb.pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: illegal actions on an empty heap, extremes, ties, overflow.
    send_word(ACT_DROP, 4'd0, '0);
    send_word(ACT_REPLACE, 4'd15, '1);
    send_word(ACT_CLEAR, 4'd0, '0);
    send_word(ACT_ADD, 4'd0, '0);
    send_word(ACT_ADD, 4'd15, '1);
    send_word(ACT_ADD, 4'd5, '0);
    send_word(ACT_ADD, 4'd5, '0);
    send_word(ACT_REPLACE, 4'd0, '1);
    send_word(ACT_DROP, 4'd0, '0);
    for (int i = 0; i < 13; i++)
      send_word(ACT_ADD, RUN_W'(15 - i), KEY_W'(64'h8000_0000_0000_0000 >> (i * 5)));
    send_word(ACT_ADD, 4'd7, '0);
    send_word(ACT_REPLACE, 4'd3, '0);
    send_word(ACT_CLEAR, 4'd15, '1);

    while (words_sent < WORD_COUNT) begin
      if (words_sent >= WORD_COUNT - QUIET_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        // noise: any action with any field values
        repeat ($urandom_range(1, 8))
          send_word(kmh_action_e'($urandom_range(0, 3)), pick_run(), pick_key());
      end else begin
        merge_session();
      end
    end
    req_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d action words, checked %0d results, %0d clears", words_sent,
             sb.checked, sb.clears);
    $display("rejects seen: %0d on a full heap, %0d on an empty heap", sb.full_rejects,
             sb.empty_rejects);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
